[rtl/core/wpf_pkg.sv]
// Shared types and codes for the waypoint path follower.
`default_nettype none
package wpf_pkg;

  typedef enum logic [2:0] {
    ST_PUSHED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_FINISHED = 3'd2,
    ST_ADVANCED = 3'd3,
    ST_DRIVING  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH,
    OP_DROP,
    OP_FIN,
    OP_TAKE,
    OP_SQX,
    OP_SQY,
    OP_SQR,
    OP_ARR_FIN,
    OP_ARR_TAKE,
    OP_NUMX,
    OP_NUMY,
    OP_NUM2,
    OP_ITER,
    OP_STORE
  } dp_op_e;

  typedef struct packed {
    logic op_pub;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic started;
    logic finished;
    logic arrive;
    logic iter_last;
    logic sel_y;
  } dp_status_t;

  localparam int unsigned WpWidth = 76;

endpackage
`default_nettype wire

[rtl/core/waypoint_path_follower.sv]
// Top level of the waypoint path follower.
// Input channel (in_valid_i/in_ready_o): kind_i = 0 pushes a waypoint
// (wp_* fields) into a QUEUE_DEPTH-entry queue, kind_i = 1 is a position
// tick (pos_x_i/pos_y_i). Every input transfer yields exactly one result
// transfer on the output channel (out_valid_o/out_ready_i).
// After the accepting edge, a push takes the push/drop step and then the
// result step; a tick that reports finished at once goes straight to the
// result step; another tick squares dX, dY and the radius for the distance
// test, then arrives or finishes, or drives: each drive component runs 16
// steps of a bit-serial divide by sqrt(dX^2+dY^2), and the two components
// share one multiplier. One item is in work at a time; the next input
// transfer is taken the cycle after the result is loaded.
// The result sits in an output register; the block accepts the next item
// while it waits and holds the following result until the receiver takes it.
// Reset empties the queue and clears the target and the started/finished
// flags; queue contents are not cleared and need no clearing pass.
`default_nettype none
module waypoint_path_follower import wpf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic               kind_i,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic signed [15:0] wp_x_i,
  input  wire logic signed [15:0] wp_y_i,
  input  wire logic signed [11:0] wp_heading_i,
  input  wire logic signed [15:0] wp_speed_i,
  input  wire logic        [15:0] wp_radius_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic        [2:0]  status_o,
  output      logic               heading_valid_o,
  output      logic signed [11:0] heading_out_o,
  output      logic signed [15:0] drive_x_o,
  output      logic signed [15:0] drive_y_o
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  wpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wpf_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .wp_x_i          (wp_x_i),
    .wp_y_i          (wp_y_i),
    .wp_heading_i    (wp_heading_i),
    .wp_speed_i      (wp_speed_i),
    .wp_radius_i     (wp_radius_i),
    .status_o        (status_o),
    .heading_valid_o (heading_valid_o),
    .heading_out_o   (heading_out_o),
    .drive_x_o       (drive_x_o),
    .drive_y_o       (drive_y_o)
  );

endmodule
`default_nettype wire

[rtl/core/wpf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/core/wpf_datapath.sv]
// Datapath: waypoint queue, target registers, shared multiplier, bit-serial divide-by-root.
`default_nettype none
module wpf_datapath import wpf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  output      dp_status_t         stat_o,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic signed [15:0] wp_x_i,
  input  wire logic signed [15:0] wp_y_i,
  input  wire logic signed [11:0] wp_heading_i,
  input  wire logic signed [15:0] wp_speed_i,
  input  wire logic        [15:0] wp_radius_i,
  output      logic        [2:0]  status_o,
  output      logic               heading_valid_o,
  output      logic signed [11:0] heading_out_o,
  output      logic signed [15:0] drive_x_o,
  output      logic signed [15:0] drive_y_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = 67;

  logic signed [15:0] px_q, py_q, wx_q, wy_q, ws_q;
  logic signed [11:0] wh_q;
  logic        [15:0] wr_q;

  logic signed [15:0] tx_q, ty_q, ts_q;
  logic        [15:0] tr_q;
  logic               started_q, finished_q;

  logic [AW-1:0] head_q, tail_q;
  logic [CW-1:0] count_q;
  logic [WpWidth-1:0] rdata;

  status_e            st_q;
  logic               hv_q;
  logic signed [11:0] hd_q;
  logic signed [15:0] dxo_q, dyo_q;

  logic [32:0] d2_q;
  logic [31:0] r2_q;
  logic [31:0] num_q;
  logic [63:0] num2_q;
  logic [15:0] qv_q;
  logic [SW-1:0] p_q;
  logic [48:0] qd_q;
  logic [3:0]  bit_q;
  logic        neg_q, sel_q;

  logic signed [16:0] dx, dy;
  logic [15:0] adx, ady, aspd;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [SW-1:0] cand;
  logic          fit;
  logic [16:0]   q_ext;
  logic [15:0]   res;

  wpf_ram #(.WIDTH(WpWidth), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_PUSH),
    .waddr_i (tail_q),
    .wdata_i ({wx_q, wy_q, wh_q, ws_q, wr_q}),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign dx   = {tx_q[15], tx_q} - {px_q[15], px_q};
  assign dy   = {ty_q[15], ty_q} - {py_q[15], py_q};
  assign adx  = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady  = dy[16] ? 16'(-dy) : dy[15:0];
  assign aspd = ts_q[15] ? 16'(-ts_q) : ts_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQX:  begin mul_a = 32'(adx);  mul_b = 32'(adx); end
      OP_SQY:  begin mul_a = 32'(ady);  mul_b = 32'(ady); end
      OP_SQR:  begin mul_a = 32'(tr_q); mul_b = 32'(tr_q); end
      OP_NUMX: begin mul_a = 32'(aspd); mul_b = 32'(adx); end
      OP_NUMY: begin mul_a = 32'(aspd); mul_b = 32'(ady); end
      OP_NUM2: begin mul_a = num_q;     mul_b = num_q; end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  assign cand = p_q + (SW'(qd_q) << ({1'b0, bit_q} + 5'd1))
                    + (SW'(d2_q) << {bit_q, 1'b0});
  assign fit  = !qv_q[15] && (cand <= SW'(num2_q));

  assign q_ext = {1'b0, qv_q};
  assign res   = neg_q ? 16'(-q_ext) : (qv_q[15] ? 16'h7fff : qv_q);

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.full       = (count_q == CW'(QUEUE_DEPTH));
  assign stat_o.started    = started_q;
  assign stat_o.finished   = finished_q;
  assign stat_o.arrive     = ({1'b0, r2_q} >= d2_q);
  assign stat_o.iter_last  = (bit_q == '0);
  assign stat_o.sel_y      = sel_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      started_q  <= 1'b0;
      finished_q <= 1'b0;
      tx_q       <= '0;
      ty_q       <= '0;
      ts_q       <= '0;
      tr_q       <= '0;
    end else begin
      case (cmd_i.op)
        OP_PUSH: begin
          tail_q  <= (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
          count_q <= count_q + CW'(1);
        end
        OP_TAKE, OP_ARR_TAKE: begin
          {tx_q, ty_q} <= rdata[75:44];
          ts_q    <= rdata[31:16];
          tr_q    <= rdata[15:0];
          head_q  <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
          count_q <= count_q - CW'(1);
          started_q <= 1'b1;
          if (cmd_i.op == OP_ARR_TAKE) begin
            finished_q <= 1'b0;
          end
        end
        OP_ARR_FIN: finished_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        px_q  <= pos_x_i;
        py_q  <= pos_y_i;
        wx_q  <= wp_x_i;
        wy_q  <= wp_y_i;
        wh_q  <= wp_heading_i;
        ws_q  <= wp_speed_i;
        wr_q  <= wp_radius_i;
        st_q  <= ST_PUSHED;
        hv_q  <= 1'b0;
        hd_q  <= '0;
        dxo_q <= '0;
        dyo_q <= '0;
      end
      OP_PUSH:     st_q <= ST_PUSHED;
      OP_DROP:     st_q <= ST_DROPPED;
      OP_FIN:      st_q <= ST_FINISHED;
      OP_ARR_FIN:  st_q <= ST_FINISHED;
      OP_TAKE: begin
        hv_q <= 1'b1;
        hd_q <= rdata[43:32];
      end
      OP_ARR_TAKE: begin
        hv_q <= 1'b1;
        hd_q <= rdata[43:32];
        st_q <= ST_ADVANCED;
      end
      OP_SQX: d2_q <= 33'(prod[31:0]);
      OP_SQY: d2_q <= d2_q + 33'(prod[31:0]);
      OP_SQR: r2_q <= prod[31:0];
      OP_NUMX: begin
        num_q <= prod[31:0];
        neg_q <= ts_q[15] ^ dx[16];
        sel_q <= 1'b0;
      end
      OP_NUMY: begin
        num_q <= prod[31:0];
        neg_q <= ts_q[15] ^ dy[16];
        sel_q <= 1'b1;
      end
      OP_NUM2: begin
        num2_q <= prod;
        qv_q   <= '0;
        p_q    <= '0;
        qd_q   <= '0;
        bit_q  <= 4'd15;
      end
      OP_ITER: begin
        if (fit) begin
          qv_q <= qv_q | (16'd1 << bit_q);
          p_q  <= cand;
          qd_q <= qd_q + (49'(d2_q) << bit_q);
        end
        bit_q <= bit_q - 4'd1;
      end
      OP_STORE: begin
        st_q <= ST_DRIVING;
        if (sel_q) begin
          dyo_q <= res;
        end else begin
          dxo_q <= res;
        end
      end
      default: ;
    endcase
    if (cmd_i.op_pub) begin
      status_o        <= st_q;
      heading_valid_o <= hv_q;
      heading_out_o   <= hd_q;
      drive_x_o       <= dxo_q;
      drive_y_o       <= dyo_q;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH)) else $error("queue count above depth");
  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_TAKE || cmd_i.op == OP_ARR_TAKE) |-> count_q != '0)
    else $error("take from empty queue");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_PUSH |=> count_q != '0 && tail_q != $past(tail_q))
    else $error("push did not advance queue");

endmodule
`default_nettype wire

[rtl/core/wpf_ctrl.sv]
// Controller: sequences pushes and ticks through the datapath and owns the output handshake.
`default_nettype none
module wpf_ctrl import wpf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic       kind_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t stat_i,
  output      dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_TICK, S_SQX, S_SQY, S_SQR, S_DEC,
    S_NUM, S_NUM2, S_ITER, S_STORE, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   sel_y_d, sel_y_q;
  logic   out_free;

  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    sel_y_d        = sel_y_q;
    cmd_o.op       = OP_NONE;
    cmd_o.op_pub   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = kind_i ? S_TICK : S_PUSH;
        end
      end
      S_PUSH: begin
        cmd_o.op = stat_i.full ? OP_DROP : OP_PUSH;
        state_d  = S_DONE;
      end
      S_TICK: begin
        if (stat_i.count_zero && (stat_i.finished || !stat_i.started)) begin
          cmd_o.op = OP_FIN;
          state_d  = S_DONE;
        end else if (!stat_i.started) begin
          cmd_o.op = OP_TAKE;
          state_d  = S_SQX;
        end else begin
          state_d  = S_SQX;
        end
      end
      S_SQX: begin cmd_o.op = OP_SQX; state_d = S_SQY; end
      S_SQY: begin cmd_o.op = OP_SQY; state_d = S_SQR; end
      S_SQR: begin cmd_o.op = OP_SQR; state_d = S_DEC; end
      S_DEC: begin
        if (stat_i.arrive) begin
          cmd_o.op = stat_i.count_zero ? OP_ARR_FIN : OP_ARR_TAKE;
          state_d  = S_DONE;
        end else begin
          sel_y_d = 1'b0;
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        cmd_o.op = sel_y_q ? OP_NUMY : OP_NUMX;
        state_d  = S_NUM2;
      end
      S_NUM2: begin cmd_o.op = OP_NUM2; state_d = S_ITER; end
      S_ITER: begin
        cmd_o.op = OP_ITER;
        if (stat_i.iter_last) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.op = OP_STORE;
        if (sel_y_q) begin
          state_d = S_DONE;
        end else begin
          sel_y_d = 1'b1;
          state_d = S_NUM;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.op_pub = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_y_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_y_q <= sel_y_d;
      if (cmd_o.op_pub) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  a_pub_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op_pub |-> out_free) else $error("result overwritten");
  a_store_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_STORE |-> sel_y_q == stat_i.sel_y)
    else $error("component select mismatch");
  a_pub_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op_pub |=> out_valid_o && state_q == S_IDLE)
    else $error("publish lost");

endmodule
`default_nettype wire
